// ===== rtl/best_fit_heap_allocator_top_assert.svh =====
// assertion macros shared by the allocator rtl
// needs clk and rst_n in the scope where a macro is used
`ifndef BEST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH
`define BEST_FIT_HEAP_ALLOCATOR_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define BFHA_ASSERT_SAME(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// condition implies consequence in the next cycle
`define BFHA_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/bfha_pkg.sv =====
// shared types and constants of the best-fit heap allocator
// no dependencies
package bfha_pkg;

    localparam int LEN_W  = 11;
    localparam int ADDR_W = 10;
    localparam int DATA_W = 8;
    localparam int ACT_W  = 2;
    localparam int ST_W   = 3;

    localparam logic [ACT_W-1:0] ACT_ALLOC = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FREE  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd3;

    localparam logic [ST_W-1:0] ST_OK        = 3'd0;
    localparam logic [ST_W-1:0] ST_ALLOC_ERR = 3'd1;
    localparam logic [ST_W-1:0] ST_FREE_ERR  = 3'd2;
    localparam logic [ST_W-1:0] ST_READ_ERR  = 3'd3;
    localparam logic [ST_W-1:0] ST_WRITE_ERR = 3'd4;

    typedef struct packed {
        logic [LEN_W-1:0] start;
        logic [LEN_W-1:0] len;
        logic             free;
    } blk_t;

    typedef struct packed {
        logic [ACT_W-1:0]  action;
        logic [LEN_W-1:0]  req_size;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] wdata;
    } req_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [ADDR_W-1:0] alloc_addr;
        logic [DATA_W-1:0] rdata;
    } res_t;

    typedef struct packed {
        logic [LEN_W-1:0] sum;
        logic [LEN_W-1:0] diff;
        logic             eq;
        logic             lt;
    } alu_res_t;

endpackage

// ===== rtl/bfha_if.sv =====
// request and response channel interfaces of the allocator
// depends on bfha_pkg
interface bfha_req_if;
    logic                        valid;
    logic                        ready;
    logic [bfha_pkg::ACT_W-1:0]  action;
    logic [bfha_pkg::LEN_W-1:0]  req_size;
    logic [bfha_pkg::ADDR_W-1:0] addr;
    logic [bfha_pkg::DATA_W-1:0] wdata;

    modport source (output valid, action, req_size, addr, wdata, input ready);
    modport sink (input valid, action, req_size, addr, wdata, output ready);
endinterface

interface bfha_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [bfha_pkg::ST_W-1:0]   status;
    logic [bfha_pkg::ADDR_W-1:0] alloc_addr;
    logic [bfha_pkg::DATA_W-1:0] rdata;

    modport source (output valid, status, alloc_addr, rdata, input ready);
    modport sink (input valid, status, alloc_addr, rdata, output ready);
endinterface

// ===== rtl/bfha_alu.sv =====
// shared add, subtract and compare unit of the allocator sequencer
// depends on bfha_pkg
module bfha_alu (
    input  logic [bfha_pkg::LEN_W-1:0] a,
    input  logic [bfha_pkg::LEN_W-1:0] b,
    output bfha_pkg::alu_res_t         res
);
    import bfha_pkg::*;

    always_comb
    begin
        res.sum  = a + b;
        res.diff = a - b;
        res.eq   = (a == b);
        res.lt   = (a < b);
    end
endmodule

// ===== rtl/bfha_ctrl.sv =====
// sequencer of the allocator: block table memory, byte memory, scan and shift steps
// depends on bfha_pkg, bfha_alu and best_fit_heap_allocator_top_assert.svh
`include "best_fit_heap_allocator_top_assert.svh"

module bfha_ctrl #(
    parameter int HEAP_BYTES = 1024,
    parameter int MAX_BLOCKS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       req_valid,
    output logic                       req_ready,
    input  bfha_pkg::req_t             req,
    output logic                       res_valid,
    input  logic                       res_free,
    output bfha_pkg::res_t             res,
    input  logic                       cfg_init,
    input  logic [bfha_pkg::LEN_W-1:0] cfg_cap,
    input  logic [bfha_pkg::LEN_W-1:0] cap
);
    import bfha_pkg::*;

    localparam int IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int AW = (HEAP_BYTES > 1) ? $clog2(HEAP_BYTES) : 1;

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_CHK, S_RD, S_EV, S_ALC, S_SH_RD, S_SH_WR,
        S_SPL1, S_SPL2, S_MARK, S_ZERO, S_FN_RD, S_FN_EV, S_RM_RD,
        S_RM_WR, S_FP_RD, S_FP_EV, S_ACC, S_ACC2, S_DONE
    } state_t;

    state_t            state_reg, state_next, ret_reg, ret_next;
    logic [ACT_W-1:0]  op_reg, op_next;
    logic [LEN_W-1:0]  size_reg, size_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [DATA_W-1:0] wd_reg, wd_next;
    logic [CW-1:0]     cnt_reg, cnt_next, i_reg, i_next;
    logic [IW-1:0]     pick_reg, pick_next;
    logic              found_reg, found_next, exact_reg, exact_next;
    logic              pfree_reg, pfree_next;
    logic [LEN_W-1:0]  best_reg, best_next, pstart_reg, pstart_next;
    logic [LEN_W-1:0]  plen_reg, plen_next, tmp_reg, tmp_next;
    logic [LEN_W-1:0]  rem_reg, rem_next, off_reg, off_next;
    logic [ST_W-1:0]   st_reg, st_next;
    logic [ADDR_W-1:0] aa_reg, aa_next;
    logic [DATA_W-1:0] rd_reg, rd_next;

    // block table memory
    blk_t          tbl_mem [MAX_BLOCKS];
    logic          t_we;
    logic [IW-1:0] t_waddr, t_raddr;
    blk_t          t_wdata, t_q;

    // byte memory
    logic [DATA_W-1:0] heap_mem [HEAP_BYTES];
    logic              h_we;
    logic [AW-1:0]     h_waddr, h_raddr;
    logic [DATA_W-1:0] h_q;

    logic [LEN_W-1:0] alu_a, alu_b;
    alu_res_t         alu_r;

    bfha_alu u_alu (
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_r)
    );

    always_ff @(posedge clk)
    begin
        if (t_we)
        begin
            tbl_mem[t_waddr] <= t_wdata;
        end
        t_q <= tbl_mem[t_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (h_we)
        begin
            heap_mem[h_waddr] <= '0;
        end
        else if (h_we == 1'b0 && state_reg == S_ACC && op_reg == ACT_WRITE
                 && found_reg && !pfree_reg)
        begin
            heap_mem[h_raddr] <= wd_reg;
        end
        h_q <= heap_mem[h_raddr];
    end

    assign req_ready  = (state_reg == S_IDLE);
    assign res_valid  = (state_reg == S_DONE);
    assign res.status     = st_reg;
    assign res.alloc_addr = aa_reg;
    assign res.rdata      = rd_reg;
    assign h_raddr        = AW'(addr_reg);

    always_comb
    begin
        state_next  = state_reg;
        ret_next    = ret_reg;
        op_next     = op_reg;
        size_next   = size_reg;
        addr_next   = addr_reg;
        wd_next     = wd_reg;
        cnt_next    = cnt_reg;
        i_next      = i_reg;
        pick_next   = pick_reg;
        found_next  = found_reg;
        exact_next  = exact_reg;
        pfree_next  = pfree_reg;
        best_next   = best_reg;
        pstart_next = pstart_reg;
        plen_next   = plen_reg;
        tmp_next    = tmp_reg;
        rem_next    = rem_reg;
        off_next    = off_reg;
        st_next     = st_reg;
        aa_next     = aa_reg;
        rd_next     = rd_reg;
        t_we        = 1'b0;
        t_waddr     = '0;
        t_wdata     = '0;
        t_raddr     = i_reg[IW-1:0];
        h_we        = 1'b0;
        h_waddr     = '0;
        alu_a       = '0;
        alu_b       = '0;

        case (state_reg)
            S_INIT:
            begin
                t_we       = 1'b1;
                t_wdata    = '{start: '0, len: cap, free: 1'b1};
                cnt_next   = CW'(1);
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next    = req.action;
                    size_next  = req.req_size;
                    addr_next  = req.addr;
                    wd_next    = req.wdata;
                    i_next     = '0;
                    found_next = 1'b0;
                    exact_next = 1'b0;
                    st_next    = ST_OK;
                    aa_next    = '0;
                    rd_next    = '0;
                    case (req.action)
                        ACT_ALLOC:
                        begin
                            if (req.req_size == '0)
                            begin
                                st_next    = ST_ALLOC_ERR;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        ACT_FREE:  state_next = S_RD;
                        default:   state_next = S_CHK;
                    endcase
                end
            end
            S_CHK:
            begin
                alu_a = LEN_W'(addr_reg);
                alu_b = cap;
                if (alu_r.lt)
                begin
                    state_next = S_RD;
                end
                else
                begin
                    st_next    = (op_reg == ACT_READ) ? ST_READ_ERR : ST_WRITE_ERR;
                    state_next = S_DONE;
                end
            end
            S_RD:
            begin
                if (i_reg == cnt_reg)
                begin
                    case (op_reg)
                        ACT_ALLOC: state_next = S_ALC;
                        ACT_FREE:
                        begin
                            st_next    = ST_FREE_ERR;
                            state_next = S_DONE;
                        end
                        default:   state_next = S_ACC;
                    endcase
                end
                else
                begin
                    state_next = S_EV;
                end
            end
            S_EV:
            begin
                i_next     = i_reg + CW'(1);
                state_next = S_RD;
                case (op_reg)
                    ACT_ALLOC:
                    begin
                        alu_a = size_reg;
                        alu_b = t_q.len;
                        if (t_q.free && alu_r.eq)
                        begin
                            pick_next   = i_reg[IW-1:0];
                            pstart_next = t_q.start;
                            plen_next   = t_q.len;
                            found_next  = 1'b1;
                            exact_next  = 1'b1;
                            state_next  = S_ALC;
                        end
                        else if (t_q.free && alu_r.lt && (!found_reg || t_q.len <= best_reg))
                        begin
                            pick_next   = i_reg[IW-1:0];
                            pstart_next = t_q.start;
                            plen_next   = t_q.len;
                            best_next   = t_q.len;
                            found_next  = 1'b1;
                        end
                    end
                    ACT_FREE:
                    begin
                        alu_a = t_q.start;
                        alu_b = LEN_W'(addr_reg);
                        if (alu_r.eq)
                        begin
                            pick_next   = i_reg[IW-1:0];
                            pstart_next = t_q.start;
                            plen_next   = t_q.len;
                            if (t_q.free)
                            begin
                                st_next    = ST_FREE_ERR;
                                state_next = S_DONE;
                            end
                            else
                            begin
                                state_next = S_FN_RD;
                            end
                        end
                    end
                    default:
                    begin
                        // owner is the last block that starts at or below the address
                        alu_a = LEN_W'(addr_reg);
                        alu_b = t_q.start;
                        if (!alu_r.lt)
                        begin
                            found_next = 1'b1;
                            pfree_next = t_q.free;
                        end
                        else
                        begin
                            state_next = S_ACC;
                        end
                    end
                endcase
            end
            S_ALC:
            begin
                if (!found_reg)
                begin
                    st_next    = ST_ALLOC_ERR;
                    state_next = S_DONE;
                end
                else if (exact_reg)
                begin
                    state_next = S_MARK;
                end
                else if (cnt_reg == CW'(MAX_BLOCKS))
                begin
                    st_next    = ST_ALLOC_ERR;
                    state_next = S_DONE;
                end
                else
                begin
                    i_next     = cnt_reg;
                    state_next = S_SH_RD;
                end
            end
            S_SH_RD:
            begin
                if (i_reg == CW'(pick_reg) + CW'(1))
                begin
                    state_next = S_SPL1;
                end
                else
                begin
                    t_raddr    = IW'(i_reg - CW'(1));
                    state_next = S_SH_WR;
                end
            end
            S_SH_WR:
            begin
                t_we       = 1'b1;
                t_waddr    = i_reg[IW-1:0];
                t_wdata    = t_q;
                i_next     = i_reg - CW'(1);
                state_next = S_SH_RD;
            end
            S_SPL1:
            begin
                alu_a      = pstart_reg;
                alu_b      = size_reg;
                tmp_next   = alu_r.sum;
                state_next = S_SPL2;
            end
            S_SPL2:
            begin
                alu_a      = plen_reg;
                alu_b      = size_reg;
                t_we       = 1'b1;
                t_waddr    = pick_reg + IW'(1);
                t_wdata    = '{start: tmp_reg, len: alu_r.diff, free: 1'b1};
                cnt_next   = cnt_reg + CW'(1);
                state_next = S_MARK;
            end
            S_MARK:
            begin
                t_we       = 1'b1;
                t_waddr    = pick_reg;
                t_wdata    = '{start: pstart_reg, len: size_reg, free: 1'b0};
                off_next   = '0;
                rem_next   = size_reg;
                aa_next    = pstart_reg[ADDR_W-1:0];
                state_next = S_ZERO;
            end
            S_ZERO:
            begin
                alu_a    = pstart_reg;
                alu_b    = off_reg;
                h_we     = 1'b1;
                h_waddr  = AW'(alu_r.sum);
                off_next = off_reg + LEN_W'(1);
                rem_next = rem_reg - LEN_W'(1);
                if (rem_reg == LEN_W'(1))
                begin
                    state_next = S_DONE;
                end
            end
            S_FN_RD:
            begin
                if (CW'(pick_reg) + CW'(1) < cnt_reg)
                begin
                    t_raddr    = pick_reg + IW'(1);
                    state_next = S_FN_EV;
                end
                else
                begin
                    state_next = S_FP_RD;
                end
            end
            S_FN_EV:
            begin
                alu_a = plen_reg;
                alu_b = t_q.len;
                if (t_q.free)
                begin
                    plen_next  = alu_r.sum;
                    i_next     = CW'(pick_reg) + CW'(1);
                    ret_next   = S_FP_RD;
                    state_next = S_RM_RD;
                end
                else
                begin
                    state_next = S_FP_RD;
                end
            end
            S_RM_RD:
            begin
                if (i_reg + CW'(1) < cnt_reg)
                begin
                    t_raddr    = IW'(i_reg + CW'(1));
                    state_next = S_RM_WR;
                end
                else
                begin
                    cnt_next   = cnt_reg - CW'(1);
                    state_next = ret_reg;
                end
            end
            S_RM_WR:
            begin
                t_we       = 1'b1;
                t_waddr    = i_reg[IW-1:0];
                t_wdata    = t_q;
                i_next     = i_reg + CW'(1);
                state_next = S_RM_RD;
            end
            S_FP_RD:
            begin
                t_we    = 1'b1;
                t_waddr = pick_reg;
                t_wdata = '{start: pstart_reg, len: plen_reg, free: 1'b1};
                if (pick_reg != '0)
                begin
                    t_raddr    = pick_reg - IW'(1);
                    state_next = S_FP_EV;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_FP_EV:
            begin
                alu_a = t_q.len;
                alu_b = plen_reg;
                if (t_q.free)
                begin
                    t_we       = 1'b1;
                    t_waddr    = pick_reg - IW'(1);
                    t_wdata    = '{start: t_q.start, len: alu_r.sum, free: 1'b1};
                    i_next     = CW'(pick_reg);
                    ret_next   = S_DONE;
                    state_next = S_RM_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ACC:
            begin
                if (!found_reg || pfree_reg)
                begin
                    st_next    = (op_reg == ACT_READ) ? ST_READ_ERR : ST_WRITE_ERR;
                    state_next = S_DONE;
                end
                else if (op_reg == ACT_WRITE)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_ACC2;
                end
            end
            S_ACC2:
            begin
                rd_next    = h_q;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // capacity write rebuilds the table as one free block
        if (cfg_init)
        begin
            t_we     = 1'b1;
            t_waddr  = '0;
            t_wdata  = '{start: '0, len: cfg_cap, free: 1'b1};
            cnt_next = CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            ret_reg   <= S_DONE;
            cnt_reg   <= CW'(1);
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        size_reg   <= size_next;
        addr_reg   <= addr_next;
        wd_reg     <= wd_next;
        i_reg      <= i_next;
        pick_reg   <= pick_next;
        found_reg  <= found_next;
        exact_reg  <= exact_next;
        pfree_reg  <= pfree_next;
        best_reg   <= best_next;
        pstart_reg <= pstart_next;
        plen_reg   <= plen_next;
        tmp_reg    <= tmp_next;
        rem_reg    <= rem_next;
        off_reg    <= off_next;
        st_reg     <= st_next;
        aa_reg     <= aa_next;
        rd_reg     <= rd_next;
    end

    `BFHA_ASSERT_SAME(a_cnt_range, 1'b1, cnt_reg != '0 && cnt_reg <= CW'(MAX_BLOCKS), "bad count")
    `BFHA_ASSERT_SAME(a_zero_len, state_reg == S_ZERO, rem_reg != '0, "zero fill with no bytes")
    `BFHA_ASSERT_NEXT(a_done_idle, state_reg == S_DONE && res_free, state_reg == S_IDLE, "no idle")
    `BFHA_ASSERT_NEXT(a_cfg_count, cfg_init, cnt_reg == CW'(1), "table not rebuilt")

endmodule

// ===== rtl/best_fit_heap_allocator_top.sv =====
// top level of the best-fit heap allocator: capacity register, response register
// depends on bfha_pkg, bfha_if and bfha_ctrl
//
// channel | dir | handshake      | payload
// req     | in  | valid / ready  | action, req_size, addr, wdata
// rsp     | out | valid / ready  | status, alloc_addr, rdata
// cfg     | in  | cfg_we         | cfg_wdata (heap capacity)
//
// one request at a time; the sequencer is busy until its response is handed off
// allocate: a read and an evaluate state per table entry scanned, a read and a write
//   state per entry moved on split, then the bytes zeroed one by one; free and byte access
//   scan the same way, and free also moves entries down on a merge, with the shared alu
// after reset the table is built in the init state, before req.ready rises
// rsp is a register: a finished response waits there while the next request is taken

module best_fit_heap_allocator_top #(
    parameter int HEAP_BYTES = 1024,
    parameter int MAX_BLOCKS = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    bfha_req_if.sink                   req,
    bfha_rsp_if.source                 rsp,
    input  logic                       cfg_we,
    input  logic [bfha_pkg::LEN_W-1:0] cfg_wdata
);
    import bfha_pkg::*;

    // capacity after reset is the heap size, capped at 1024
    localparam logic [LEN_W-1:0] CAP_RST = LEN_W'((HEAP_BYTES < 1024) ? HEAP_BYTES : 1024);

    logic [LEN_W-1:0] cap_reg, cap_next;
    logic             out_valid_reg;
    res_t             out_reg;

    req_t req_pl;
    res_t ctrl_res;
    logic ctrl_res_valid;
    logic out_free;

    // clamp the written capacity into 1 .. heap size
    always_comb
    begin
        cap_next = cap_reg;
        if (cfg_we)
        begin
            if (cfg_wdata == '0)
            begin
                cap_next = LEN_W'(1);
            end
            else if (32'(cfg_wdata) > HEAP_BYTES)
            begin
                cap_next = LEN_W'(HEAP_BYTES);
            end
            else
            begin
                cap_next = cfg_wdata;
            end
        end
    end

    assign req_pl.action   = req.action;
    assign req_pl.req_size = req.req_size;
    assign req_pl.addr     = req.addr;
    assign req_pl.wdata    = req.wdata;

    // output register is free when empty or being drained this cycle
    assign out_free = !out_valid_reg || rsp.ready;

    bfha_ctrl #(
        .HEAP_BYTES (HEAP_BYTES),
        .MAX_BLOCKS (MAX_BLOCKS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .req       (req_pl),
        .res_valid (ctrl_res_valid),
        .res_free  (out_free),
        .res       (ctrl_res),
        .cfg_init  (cfg_we),
        .cfg_cap   (cap_next),
        .cap       (cap_reg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= CAP_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cap_reg <= cap_next;
            if (out_free)
            begin
                out_valid_reg <= ctrl_res_valid;
            end
        end
    end

    // response payload
    always_ff @(posedge clk)
    begin
        if (out_free && ctrl_res_valid)
        begin
            out_reg <= ctrl_res;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_reg.status;
    assign rsp.alloc_addr = out_reg.alloc_addr;
    assign rsp.rdata      = out_reg.rdata;

endmodule
